>>> hdl/bptc_pkg.sv
package bptc_pkg;

  // Field widths
  localparam int RAW_W      = 24;
  localparam int TEMP_W     = 25;
  localparam int PRESS_W    = 36;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Fraction bits of the scaled raw readings
  localparam int FRAC = 19;

  // Register stages from input acceptance to the output register
  localparam int NUM_STAGES = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_COEF    = 3'd0,
    REG_PRESS_OFFSET = 3'd1,
    REG_PRESS_LINEAR = 3'd2,
    REG_TEMP_CROSS   = 3'd3,
    REG_CROSS_LINEAR = 3'd4,
    REG_PRESS_SQUARE = 3'd5,
    REG_CROSS_SQUARE = 3'd6,
    REG_PRESS_CUBE   = 3'd7
  } cfg_reg_t;

endpackage

>>> hdl/baro_pressure_temp_compensation_core.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_pressure_raw, in_temperature_raw
// out_      output     out_valid/out_ready  out_temperature_q8, out_pressure_q6
// cfg_      input      cfg_we (no wait)     cfg_index, cfg_data
//
// Eight register stages, one transaction per cycle while the output is not stalled.
// Each Q19 product is split into two 24-bit-class partial products in one
// stage and summed in the next, which sets the stage count.
// Reset clears the stage valid bits and all coefficient registers.
// A stall at the output freezes every stage together; in_ready is low while
// the output holds an untaken result.
module baro_pressure_temp_compensation_core
  import bptc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [RAW_W-1:0]      in_pressure_raw,
  input  logic signed [RAW_W-1:0]      in_temperature_raw,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [TEMP_W-1:0]     out_temperature_q8,
  output logic signed [PRESS_W-1:0]    out_pressure_q6,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  // Coefficient registers
  logic [23:0]        temp_coef_r;
  logic signed [19:0] c00_r, c10_r;
  logic signed [15:0] c01_r, c11_r, c20_r, c21_r, c30_r;
  logic signed [11:0] c0, c1;

  assign c0 = $signed(temp_coef_r[23:12]);
  assign c1 = $signed(temp_coef_r[11:0]);

  // Write a coefficient, keeping only the register's own width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coef_r <= '0;
      c00_r       <= '0;
      c10_r       <= '0;
      c01_r       <= '0;
      c11_r       <= '0;
      c20_r       <= '0;
      c21_r       <= '0;
      c30_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TEMP_COEF:    temp_coef_r <= cfg_data;
        REG_PRESS_OFFSET: c00_r       <= $signed(cfg_data[19:0]);
        REG_PRESS_LINEAR: c10_r       <= $signed(cfg_data[19:0]);
        REG_TEMP_CROSS:   c01_r       <= $signed(cfg_data[15:0]);
        REG_CROSS_LINEAR: c11_r       <= $signed(cfg_data[15:0]);
        REG_PRESS_SQUARE: c20_r       <= $signed(cfg_data[15:0]);
        REG_CROSS_SQUARE: c21_r       <= $signed(cfg_data[15:0]);
        REG_PRESS_CUBE:   c30_r       <= $signed(cfg_data[15:0]);
        default:          temp_coef_r <= temp_coef_r;
      endcase
    end
  end

  // Pipeline advance: every stage moves unless the output result is held
  logic                  en;
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;

  assign en        = !vld_r[NUM_STAGES-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NUM_STAGES-1];
  assign vld_nxt   = {vld_r[NUM_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: first-order products
  logic signed [RAW_W-1:0] s1_p_r, s1_t_r;
  logic signed [39:0]      s1_m30_r, s1_m21_r;
  logic signed [35:0]      s1_tc_r;

  // Stage 2: add second coefficient, finish temperature
  logic signed [RAW_W-1:0]  s2_p_r, s2_t_r;
  logic signed [39:0]       s2_pa0_r, s2_tb0_r;
  logic signed [TEMP_W-1:0] s2_temp_r;
  logic signed [39:0]       pa0_nxt, tb0_nxt;
  logic signed [36:0]       temp19_nxt;

  assign pa0_nxt    = s1_m30_r + (40'(c20_r) <<< FRAC);
  assign tb0_nxt    = s1_m21_r + (40'(c11_r) <<< FRAC);
  assign temp19_nxt = (37'(c0) <<< (FRAC - 1)) + 37'(s1_tc_r);

  // Stage 3: partial products of the first Q19 multiply
  logic signed [RAW_W-1:0]  s3_p_r, s3_t_r;
  logic signed [46:0]       s3_pah_r, s3_tbh_r;
  logic signed [41:0]       s3_pal_r, s3_tbl_r;
  logic signed [TEMP_W-1:0] s3_temp_r;

  // Stage 4: recombine, floor to Q19, add third coefficient
  logic signed [RAW_W-1:0]  s4_p_r, s4_t_r;
  logic signed [44:0]       s4_pa1_r, s4_tb1_r;
  logic signed [TEMP_W-1:0] s4_temp_r;
  logic signed [63:0]       pa1_sum_nxt, tb1_sum_nxt;

  assign pa1_sum_nxt = (64'(s3_pah_r) <<< 17) + 64'(s3_pal_r) + (64'(c10_r) <<< (2 * FRAC));
  assign tb1_sum_nxt = (64'(s3_tbh_r) <<< 17) + 64'(s3_tbl_r) + (64'(c01_r) <<< (2 * FRAC));

  // Stage 5: partial products of the second Q19 multiply
  logic signed [46:0]       s5_pah_r, s5_pal_r, s5_tbh_r, s5_tbl_r;
  logic signed [TEMP_W-1:0] s5_temp_r;

  // Stage 6: recombine and floor to Q19
  logic signed [48:0]       s6_pa2_r, s6_tb2_r;
  logic signed [TEMP_W-1:0] s6_temp_r;
  logic signed [68:0]       pa2_sum_nxt, tb2_sum_nxt;

  assign pa2_sum_nxt = (69'(s5_pah_r) <<< 22) + 69'(s5_pal_r);
  assign tb2_sum_nxt = (69'(s5_tbh_r) <<< 22) + 69'(s5_tbl_r);

  // Stage 7: final sum, floor to Q6
  logic signed [37:0]       s7_press6_r;
  logic signed [TEMP_W-1:0] s7_temp_r;
  logic signed [50:0]       press19_nxt;

  assign press19_nxt = 51'(s6_pa2_r) + 51'(s6_tb2_r) + (51'(c00_r) <<< FRAC);

  // Stage 8: saturate into the output register
  logic signed [PRESS_W-1:0] s8_press_r, press_sat_nxt;
  logic signed [TEMP_W-1:0]  s8_temp_r;
  logic                      press_fits;

  assign press_fits = (s7_press6_r[37:PRESS_W-1] == '0) || (s7_press6_r[37:PRESS_W-1] == '1);

  always_comb begin
    if (press_fits) begin
      press_sat_nxt = s7_press6_r[PRESS_W-1:0];
    end else if (s7_press6_r[37]) begin
      press_sat_nxt = {1'b1, {(PRESS_W-1){1'b0}}};
    end else begin
      press_sat_nxt = {1'b0, {(PRESS_W-1){1'b1}}};
    end
  end

  // Advance the payload of all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r      <= in_pressure_raw;
      s1_t_r      <= in_temperature_raw;
      s1_m30_r    <= c30_r * in_pressure_raw;
      s1_m21_r    <= c21_r * in_pressure_raw;
      s1_tc_r     <= c1 * in_temperature_raw;

      s2_p_r      <= s1_p_r;
      s2_t_r      <= s1_t_r;
      s2_pa0_r    <= pa0_nxt;
      s2_tb0_r    <= tb0_nxt;
      s2_temp_r   <= temp19_nxt[35:11];

      s3_p_r      <= s2_p_r;
      s3_t_r      <= s2_t_r;
      s3_pah_r    <= $signed(s2_pa0_r[39:17]) * s2_p_r;
      s3_pal_r    <= $signed({1'b0, s2_pa0_r[16:0]}) * s2_p_r;
      s3_tbh_r    <= $signed(s2_tb0_r[39:17]) * s2_p_r;
      s3_tbl_r    <= $signed({1'b0, s2_tb0_r[16:0]}) * s2_p_r;
      s3_temp_r   <= s2_temp_r;

      s4_p_r      <= s3_p_r;
      s4_t_r      <= s3_t_r;
      s4_pa1_r    <= pa1_sum_nxt[63:FRAC];
      s4_tb1_r    <= tb1_sum_nxt[63:FRAC];
      s4_temp_r   <= s3_temp_r;

      s5_pah_r    <= $signed(s4_pa1_r[44:22]) * s4_p_r;
      s5_pal_r    <= $signed({1'b0, s4_pa1_r[21:0]}) * s4_p_r;
      s5_tbh_r    <= $signed(s4_tb1_r[44:22]) * s4_t_r;
      s5_tbl_r    <= $signed({1'b0, s4_tb1_r[21:0]}) * s4_t_r;
      s5_temp_r   <= s4_temp_r;

      s6_pa2_r    <= pa2_sum_nxt[67:FRAC];
      s6_tb2_r    <= tb2_sum_nxt[67:FRAC];
      s6_temp_r   <= s5_temp_r;

      s7_press6_r <= press19_nxt[50:13];
      s7_temp_r   <= s6_temp_r;

      s8_press_r  <= press_sat_nxt;
      s8_temp_r   <= s7_temp_r;
    end
  end

  assign out_temperature_q8 = s8_temp_r;
  assign out_pressure_q6    = s8_press_r;

  // A held result freezes the valid line
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid line moved during a stall");

  // A transaction in the last internal stage reaches the output
  a_reach_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[NUM_STAGES-2] |=> out_valid)
    else $error("transaction lost before the output register");

  // An overflowing positive sum comes out as the positive limit
  a_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[NUM_STAGES-2] && !press_fits && !s7_press6_r[37]
    |=> out_pressure_q6 == {1'b0, {(PRESS_W-1){1'b1}}})
    else $error("pressure did not saturate high");

endmodule
